FILE: hdl/arpc_pkg.sv
package arpc_pkg;

  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_SWEEP  = 2'd2;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_MISS = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  localparam logic [31:0] LIFETIME_RESET = 32'd30000;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] ip_address;
    logic [47:0] mac_address;
    logic [31:0] now;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] found_mac;
    logic [7:0]  entry_count;
  } out_word_t;

  typedef struct packed {
    logic [31:0] key;
    logic [47:0] mac;
    logic [31:0] expiry;
  } entry_t;

  typedef struct packed {
    logic load;
    logic srch_rd;
    logic srch_upd;
    logic shift_init;
    logic shift_rd;
    logic shift_wr;
    logic put;
    logic swp_rd;
    logic swp_chk;
    logic swp_end;
    logic mark_full;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       srch_more;
    logic       hit;
    logic       full;
    logic       shift_more;
    logic       swp_more;
    logic       out_free;
  } dp_stat_t;

endpackage

FILE: hdl/arp_cache_table.sv
// arp cache: sorted table of ipv4 -> mac entries with expiry times
// input channel: in_valid_i / in_stall_o, word in_word_i (operation, ip_address,
//   mac_address, now); a word is taken when valid is high and stall is low
// output channel: out_valid_o / out_stall_i, one result word per input word
//   (status, found_mac, entry_count), held steady while the receiver stalls
// config channel: cfg_valid_i / cfg_ready_o writes the entry lifetime
// one operation at a time; the controller issues at most one table memory
//   access per step: lookup is a binary search of about log2(count)+1 probes,
//   each a read step and then a compare step; update runs the same search,
//   then reports full on a miss in a full table, rewrites the entry in place
//   on a hit, or else shifts the entries above the slot up one and writes the
//   new one; sweep reads every entry and writes the ones still live down
//   in order; the next word can be taken in the cycle after its result is loaded
// a finished result sits in the output register; if the receiver stalls,
//   the block holds in its done step until that register frees up
// reset clears the entry count (table empty) and sets the lifetime to 30000;
//   the table memory itself is not cleared, no clearing pass is needed
module arp_cache_table #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  arpc_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output arpc_pkg::out_word_t out_word_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [31:0]         cfg_data_i
);
  import arpc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     cfg_we;

  assign cfg_we = cfg_valid_i && cfg_ready_o;

  arpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_word_i.operation),
    .in_stall_o (in_stall_o),
    .cfg_ready_o(cfg_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  arpc_dp #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word_i),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

endmodule

FILE: hdl/arpc_ram.sv
module arpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/arpc_dp.sv
module arpc_dp #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  arpc_pkg::in_word_t in_word_i,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_data_i,
  input  arpc_pkg::dp_cmd_t  cmd_i,
  output arpc_pkg::dp_stat_t stat_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output arpc_pkg::out_word_t out_word_o
);
  import arpc_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  logic [31:0]   lifetime_q;
  in_word_t      req_q;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [CW-1:0] idx_q, idx_d, keep_q, keep_d;
  logic          hit_q, hit_d, full_q, full_d;
  logic [47:0]   hit_mac_q, hit_mac_d;
  logic          out_valid_q, out_valid_d;
  out_word_t     out_word_q, out_word_d;

  logic [CW-1:0] mid;
  logic [CW-1:0] idx_m1;
  logic [32:0]   exp_sum;
  entry_t        new_entry, rdata;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata;
  logic [CW+7:0] count_ext;

  assign mid       = lo_q + ((hi_q - lo_q) >> 1);
  assign idx_m1    = idx_q - CW'(1);
  assign exp_sum   = {1'b0, req_q.now} + {1'b0, lifetime_q};
  assign count_ext = {8'd0, count_q};

  always_comb begin
    new_entry.key    = req_q.ip_address;
    new_entry.mac    = req_q.mac_address;
    // saturate expiry at the top of the time range
    new_entry.expiry = exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];
  end

  arpc_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    raddr = idx_q[AW-1:0];
    if (cmd_i.srch_rd) begin
      raddr = mid[AW-1:0];
    end else if (cmd_i.shift_rd) begin
      raddr = idx_m1[AW-1:0];
    end
    we    = 1'b0;
    waddr = idx_q[AW-1:0];
    wdata = rdata;
    if (cmd_i.put) begin
      we    = 1'b1;
      waddr = lo_q[AW-1:0];
      wdata = new_entry;
    end else if (cmd_i.shift_wr) begin
      we = 1'b1;
    end else if (cmd_i.swp_chk && (rdata.expiry >= req_q.now)) begin
      we    = 1'b1;
      waddr = keep_q[AW-1:0];
    end
  end

  always_comb begin
    count_d     = count_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    idx_d       = idx_q;
    keep_d      = keep_q;
    hit_d       = hit_q;
    full_d      = full_q;
    hit_mac_d   = hit_mac_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_word_d  = out_word_q;
    if (cmd_i.load) begin
      lo_d   = '0;
      hi_d   = count_q;
      idx_d  = '0;
      keep_d = '0;
      hit_d  = 1'b0;
      full_d = 1'b0;
    end
    if (cmd_i.srch_upd) begin
      if (rdata.key < req_q.ip_address) begin
        lo_d = mid + CW'(1);
      end else begin
        hi_d = mid;
      end
      // keys are unique, so the lower-bound slot of a present key gets probed
      if (rdata.key == req_q.ip_address) begin
        hit_d     = 1'b1;
        hit_mac_d = rdata.mac;
      end
    end
    if (cmd_i.shift_init) begin
      idx_d = count_q;
    end
    if (cmd_i.shift_wr) begin
      idx_d = idx_m1;
    end
    if (cmd_i.put && !hit_q) begin
      count_d = count_q + CW'(1);
    end
    if (cmd_i.swp_chk) begin
      idx_d = idx_q + CW'(1);
      if (rdata.expiry >= req_q.now) begin
        keep_d = keep_q + CW'(1);
      end
    end
    if (cmd_i.swp_end) begin
      count_d = keep_q;
    end
    if (cmd_i.mark_full) begin
      full_d = 1'b1;
    end
    if (cmd_i.finish) begin
      out_valid_d            = 1'b1;
      out_word_d.status      = STATUS_OK;
      out_word_d.found_mac   = '0;
      out_word_d.entry_count = count_ext[7:0];
      if (req_q.operation == OP_UPDATE && full_q) begin
        out_word_d.status = STATUS_FULL;
      end else if (req_q.operation == OP_LOOKUP) begin
        if (hit_q) begin
          out_word_d.found_mac = hit_mac_q;
        end else begin
          out_word_d.status = STATUS_MISS;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lifetime_q  <= LIFETIME_RESET;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        lifetime_q <= cfg_data_i;
      end
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_word_i;
    end
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    idx_q      <= idx_d;
    keep_q     <= keep_d;
    hit_q      <= hit_d;
    full_q     <= full_d;
    hit_mac_q  <= hit_mac_d;
    out_word_q <= out_word_d;
  end

  assign stat_o.op         = req_q.operation;
  assign stat_o.srch_more  = lo_q < hi_q;
  assign stat_o.hit        = hit_q;
  assign stat_o.full       = count_q == DEPTH_C;
  assign stat_o.shift_more = idx_q > lo_q;
  assign stat_o.swp_more   = idx_q < count_q;
  assign stat_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

FILE: hdl/arpc_ctrl.sv
module arpc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [1:0]         in_op_i,
  output logic               in_stall_o,
  output logic               cfg_ready_o,
  input  arpc_pkg::dp_stat_t stat_i,
  output arpc_pkg::dp_cmd_t  cmd_o
);
  import arpc_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SRCH     = 4'd1;
  localparam logic [3:0] S_SRCH_CMP = 4'd2;
  localparam logic [3:0] S_SHIFT    = 4'd3;
  localparam logic [3:0] S_SHIFT_WR = 4'd4;
  localparam logic [3:0] S_PUT      = 4'd5;
  localparam logic [3:0] S_SWP      = 4'd6;
  localparam logic [3:0] S_SWP_CHK  = 4'd7;
  localparam logic [3:0] S_DONE     = 4'd8;

  logic [3:0] state_q, state_d;
  logic       accept;

  assign in_stall_o  = state_q != S_IDLE;
  assign cfg_ready_o = state_q == S_IDLE;
  assign accept      = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          unique case (in_op_i) inside
            OP_UPDATE, OP_LOOKUP: state_d = S_SRCH;
            OP_SWEEP:             state_d = S_SWP;
            default:              state_d = S_DONE;
          endcase
        end
      end
      S_SRCH: begin
        if (stat_i.srch_more) begin
          cmd_o.srch_rd = 1'b1;
          state_d       = S_SRCH_CMP;
        end else if (stat_i.op == OP_LOOKUP || stat_i.hit) begin
          state_d = (stat_i.op == OP_LOOKUP) ? S_DONE : S_PUT;
        end else if (stat_i.full) begin
          cmd_o.mark_full = 1'b1;
          state_d         = S_DONE;
        end else begin
          cmd_o.shift_init = 1'b1;
          state_d          = S_SHIFT;
        end
      end
      S_SRCH_CMP: begin
        cmd_o.srch_upd = 1'b1;
        state_d        = S_SRCH;
      end
      // move entries up one slot, from the top down to the insert point
      S_SHIFT: begin
        if (stat_i.shift_more) begin
          cmd_o.shift_rd = 1'b1;
          state_d        = S_SHIFT_WR;
        end else begin
          state_d = S_PUT;
        end
      end
      S_SHIFT_WR: begin
        cmd_o.shift_wr = 1'b1;
        state_d        = S_SHIFT;
      end
      S_PUT: begin
        cmd_o.put = 1'b1;
        state_d   = S_DONE;
      end
      S_SWP: begin
        if (stat_i.swp_more) begin
          cmd_o.swp_rd = 1'b1;
          state_d      = S_SWP_CHK;
        end else begin
          cmd_o.swp_end = 1'b1;
          state_d       = S_DONE;
        end
      end
      S_SWP_CHK: begin
        cmd_o.swp_chk = 1'b1;
        state_d       = S_SWP;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: tb/tb_top.sv
module tb_top;
  import arpc_pkg::*;

  localparam int TABLE_DEPTH = 128;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int POOL_SIZE = 48;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_word_t    in_word_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_word_t   out_word_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i = '0;

  arp_cache_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // shadow copy of the cache
  logic [31:0] shadow_ip  [TABLE_DEPTH];
  logic [47:0] shadow_mac [TABLE_DEPTH];
  logic [31:0] shadow_exp [TABLE_DEPTH];
  int          shadow_count = 0;
  logic [31:0] shadow_lifetime = LIFETIME_RESET;

  out_word_t   due_replies[$];
  out_word_t   oldest_reply;
  out_word_t   fresh_reply;

  int mismatches = 0;
  int words_in = 0;
  int replies_checked = 0;
  int lookup_hits = 0;
  int lookup_misses = 0;
  int full_replies = 0;
  int lifetime_writes = 0;
  int deepest_table = 0;

  bit idle_on = 1'b0;
  int burst_left = 0;
  int hold_cycles = 0;
  int stall_run = 0;
  bit stall_level = 1'b0;

  logic [31:0] ip_pool [POOL_SIZE];

  function automatic logic [31:0] expiry_from(input logic [31:0] tnow);
    logic [32:0] sum;
    sum = {1'b0, tnow} + {1'b0, shadow_lifetime};
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  // applies one word to the shadow table and gives the reply it should cause
  function automatic out_word_t cache_outcome(input in_word_t w);
    out_word_t r;
    int        slot;
    int        keep;
    int        i;
    bit        present;
    r = '0;
    r.status = STATUS_OK;
    slot = 0;
    while (slot < shadow_count && shadow_ip[slot] < w.ip_address) slot++;
    present = (slot < shadow_count) && (shadow_ip[slot] == w.ip_address);
    case (w.operation)
      OP_UPDATE: begin
        if (!present && shadow_count >= TABLE_DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          if (!present) begin
            for (i = shadow_count; i > slot; i--) begin
              shadow_ip[i]  = shadow_ip[i-1];
              shadow_mac[i] = shadow_mac[i-1];
              shadow_exp[i] = shadow_exp[i-1];
            end
            shadow_count++;
          end
          shadow_ip[slot]  = w.ip_address;
          shadow_mac[slot] = w.mac_address;
          shadow_exp[slot] = expiry_from(w.now);
        end
      end
      OP_LOOKUP: begin
        if (present) r.found_mac = shadow_mac[slot];
        else r.status = STATUS_MISS;
      end
      OP_SWEEP: begin
        keep = 0;
        for (i = 0; i < shadow_count; i++) begin
          if (shadow_exp[i] >= w.now) begin
            shadow_ip[keep]  = shadow_ip[i];
            shadow_mac[keep] = shadow_mac[i];
            shadow_exp[keep] = shadow_exp[i];
            keep++;
          end
        end
        shadow_count = keep;
      end
      default: ;
    endcase
    r.entry_count = shadow_count[7:0];
    return r;
  endfunction

  function automatic logic [47:0] rand_mac();
    logic [63:0] r64;
    r64 = {$urandom(), $urandom()};
    return r64[47:0];
  endfunction

  task automatic note_mismatch(input string msg);
    if (mismatches < 100) $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // reply checker, also predicts each accepted word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (due_replies.size() == 0) begin
          note_mismatch("reply word with nothing outstanding");
        end else begin
          oldest_reply = due_replies.pop_front();
          if (out_word_o.status !== oldest_reply.status)
            note_mismatch($sformatf("status %0d, want %0d",
                                    out_word_o.status, oldest_reply.status));
          if (out_word_o.found_mac !== oldest_reply.found_mac)
            note_mismatch($sformatf("found_mac %012h, want %012h",
                                    out_word_o.found_mac, oldest_reply.found_mac));
          if (out_word_o.entry_count !== oldest_reply.entry_count)
            note_mismatch($sformatf("entry_count %0d, want %0d",
                                    out_word_o.entry_count, oldest_reply.entry_count));
          replies_checked++;
        end
      end
      if (in_valid_i && !in_stall_o) begin
        fresh_reply = cache_outcome(in_word_i);
        due_replies.push_back(fresh_reply);
        words_in++;
        if (in_word_i.operation == OP_LOOKUP) begin
          if (fresh_reply.status == STATUS_OK) lookup_hits++;
          else lookup_misses++;
        end
        if (fresh_reply.status == STATUS_FULL) full_replies++;
        if (shadow_count > deepest_table) deepest_table = shadow_count;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        shadow_lifetime = cfg_data_i;
        lifetime_writes++;
      end
    end
  end

  // receiver: long hold-off on request, no stalls while idle_on is off, else random stall runs
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles--;
    end else if (!idle_on) begin
      out_stall_i <= 1'b0;
    end else begin
      if (stall_run == 0) begin
        stall_level = !stall_level;
        stall_run = stall_level ? $urandom_range(1, 6) : $urandom_range(1, 12);
      end
      stall_run--;
      out_stall_i <= stall_level;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_top NOT OK");
    $finish;
  end

  task automatic send_word(input in_word_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = idle_on ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic issue(input logic [1:0] op, input logic [31:0] ip,
                       input logic [47:0] mac, input logic [31:0] tnow);
    in_word_t w;
    w.operation   = op;
    w.ip_address  = ip;
    w.mac_address = mac;
    w.now         = tnow;
    send_word(w);
  endtask

  task automatic drain_replies();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (due_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_lifetime(input logic [31:0] value);
    drain_replies();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_directed();
    idle_on = 1'b1;
    issue(OP_LOOKUP, 32'h0, 48'h0, 32'h0);
    issue(OP_SWEEP, 32'h0, 48'h0, 32'h0);
    issue(OP_UNUSED, 32'h0, 48'h0, 32'h0);
    issue(OP_UPDATE, 32'h0, 48'h0, 32'h0);
    // saturating expiry
    issue(OP_UPDATE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    issue(OP_UPDATE, 32'h8000_0000, 48'h1234_5678_9ABC, 32'd100);
    issue(OP_LOOKUP, 32'h0, 48'hFFFF_FFFF_FFFF, 32'h0);
    issue(OP_LOOKUP, 32'hFFFF_FFFF, 48'h0, 32'h0);
    issue(OP_LOOKUP, 32'h0001_2345, 48'h0, 32'h0);
    // refresh in place
    issue(OP_UPDATE, 32'h8000_0000, 48'hFEDC_BA98_7654, 32'd200);
    issue(OP_LOOKUP, 32'h8000_0000, 48'h0, 32'h0);
    issue(OP_UNUSED, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    issue(OP_SWEEP, 32'h0, 48'h0, 32'd30100);
    // expiry equal to now survives
    issue(OP_SWEEP, 32'h0, 48'h0, 32'd30200);
    issue(OP_LOOKUP, 32'h0, 48'h0, 32'h0);
    issue(OP_LOOKUP, 32'h8000_0000, 48'h0, 32'h0);
    issue(OP_SWEEP, 32'h0, 48'h0, 32'hFFFF_FFFF);
    issue(OP_LOOKUP, 32'hFFFF_FFFF, 48'h0, 32'h0);
    drain_replies();
  endtask

  task automatic test_lifetime_extremes();
    write_lifetime(32'd0);
    issue(OP_UPDATE, 32'h0A00_0001, rand_mac(), 32'd5000);
    issue(OP_SWEEP, 32'h0, 48'h0, 32'd5000);
    issue(OP_LOOKUP, 32'h0A00_0001, 48'h0, 32'h0);
    issue(OP_SWEEP, 32'h0, 48'h0, 32'd5001);
    issue(OP_LOOKUP, 32'h0A00_0001, 48'h0, 32'h0);
    write_lifetime(32'hFFFF_FFFF);
    issue(OP_UPDATE, 32'h0A00_0002, rand_mac(), 32'd1);
    issue(OP_UPDATE, 32'h0A00_0003, rand_mac(), 32'd0);
    issue(OP_SWEEP, 32'h0, 48'h0, 32'hFFFF_FFFF);
    issue(OP_LOOKUP, 32'h0A00_0002, 48'h0, 32'h0);
    issue(OP_LOOKUP, 32'h0A00_0003, 48'h0, 32'h0);
    drain_replies();
  endtask

  task automatic test_table_full();
    logic [31:0] first_ip;
    int          k;
    write_lifetime(32'd1000);
    issue(OP_SWEEP, 32'h0, 48'h0, 32'hFFFF_FFFF);
    first_ip = 32'hFFFF_0000 - 32'h0135_7913;
    // descending keys force the longest shifts
    for (k = 1; k <= 70; k++)
      issue(OP_UPDATE, 32'hFFFF_0000 - k * 32'h0135_7913, rand_mac(), $urandom_range(0, 5000));
    for (k = 0; k < 70; k++)
      issue(OP_UPDATE, $urandom(), rand_mac(), $urandom_range(0, 5000));
    issue(OP_UPDATE, first_ip, rand_mac(), 32'd7000);
    issue(OP_LOOKUP, first_ip, 48'h0, 32'h0);
    issue(OP_UPDATE, 32'h0000_0001, rand_mac(), 32'd7000);
    issue(OP_SWEEP, 32'h0, 48'h0, 32'd5500);
    issue(OP_SWEEP, 32'h0, 48'h0, 32'hFFFF_FFFF);
    drain_replies();
  endtask

  task automatic test_backpressure();
    int k;
    write_lifetime(LIFETIME_RESET);
    idle_on = 1'b0;
    hold_cycles = HOLD_OFF_CYCLES;
    for (k = 0; k < 12; k++)
      issue((k % 3 == 0) ? OP_LOOKUP : OP_UPDATE, ip_pool[k], rand_mac(), 32'd10 * k);
    drain_replies();
    idle_on = 1'b1;
  endtask

  task automatic run_random_phase(input logic [31:0] lifetime, input int count);
    in_word_t    w;
    logic [31:0] clock_now;
    int          step;
    int          pick;
    int          k;
    write_lifetime(lifetime);
    step = (lifetime > 32'd4000) ? 500 : int'(lifetime / 4) + 1;
    clock_now = $urandom_range(0, 1 << 20);
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      w.ip_address  = ($urandom_range(0, 9) == 0) ? $urandom()
                                                  : ip_pool[$urandom_range(0, POOL_SIZE - 1)];
      w.mac_address = rand_mac();
      w.now         = clock_now + $urandom_range(0, 3);
      if (pick < 45) begin
        w.operation = OP_UPDATE;
      end else if (pick < 80) begin
        w.operation = OP_LOOKUP;
      end else if (pick < 94) begin
        w.operation = OP_SWEEP;
      end else if (pick < 97) begin
        w.operation = OP_UNUSED;
        w.now = $urandom();
      end else begin
        // noise: arbitrary time, may expire everything or nothing
        w.operation = 2'($urandom_range(0, 2));
        w.now = $urandom();
      end
      send_word(w);
      clock_now += $urandom_range(0, step);
    end
    drain_replies();
  endtask

  task automatic test_random();
    run_random_phase(32'd25 + $urandom_range(0, 100), 140);
    run_random_phase(32'd0, 140);
    idle_on = 1'b0;
    run_random_phase(32'hFFFF_FFFF, 140);
    idle_on = 1'b1;
    run_random_phase($urandom(), 140);
    run_random_phase(LIFETIME_RESET, 140);
    run_random_phase($urandom_range(200, 3000), 140);
  endtask

  initial begin
    int k;
    for (k = 0; k < POOL_SIZE; k++) ip_pool[k] = $urandom();
    ip_pool[0] = 32'h0;
    ip_pool[1] = 32'hFFFF_FFFF;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_lifetime_extremes();
    test_table_full();
    test_backpressure();
    test_random();

    drain_replies();
    repeat (300) @(posedge clk_i);
    $display("%0d words through the cache, %0d replies checked: %0d lookup hits, %0d misses",
             words_in, replies_checked, lookup_hits, lookup_misses);
    $display("%0d table-full updates, table reached %0d entries, %0d lifetime writes",
             full_replies, deepest_table, lifetime_writes);
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/arpc_pkg.sv
hdl/arpc_ram.sv
hdl/arpc_dp.sv
hdl/arpc_ctrl.sv
hdl/arp_cache_table.sv
tb/tb_top.sv
